/* hw/rtl/gbc_pkg.sv */
// gbc_pkg: shared types and constants for the 1bpp clipped glyph blitter
// used by gbc_issue and glyph_blit_1bpp_clipped_top; no dependencies
package gbc_pkg;

  localparam int OP_W    = 2;
  localparam int POS_W   = 11;
  localparam int GDIM_W  = 7;
  localparam int BYTE_W  = 8;
  localparam int RADDR_W = 15;
  localparam int DIM_W   = 10;
  localparam int CRD_W   = 12;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [OP_W-1:0] {
    OP_START = 2'd0,
    OP_BYTE  = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'b1;

  typedef enum logic {
    UOP_RMW  = 1'b0,
    UOP_READ = 1'b1
  } uop_kind_t;

  typedef struct packed {
    uop_kind_t         kind;
    logic              oob;
    logic              pen;
    logic [BYTE_W-1:0] mask;
    logic [BYTE_W-1:0] bits;
  } uop_t;

endpackage

/* hw/rtl/gbc_ram.sv */
// gbc_ram: generic single-write, single-read memory with registered read data
// no dependencies; read during a write to the same entry returns the old data
module gbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32768,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/gbc_issue.sv */
// gbc_issue: input words to framebuffer micro-ops (glyph state, clipping, address)
// depends on gbc_pkg; feeds the read-modify-write stage in the top level
module gbc_issue #(
  parameter int MAX_GLYPH_SIZE = 64,
  parameter int MEM_DEPTH = 32768,
  parameter int AW = 15
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         clr_busy,
  input  logic [gbc_pkg::DIM_W-1:0]    scr_w,
  input  logic [gbc_pkg::DIM_W-1:0]    scr_h,
  input  logic [7:0]                   stride,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [gbc_pkg::OP_W-1:0]     op,
  input  logic [gbc_pkg::POS_W-1:0]    origin_x,
  input  logic [gbc_pkg::POS_W-1:0]    origin_y,
  input  logic [gbc_pkg::GDIM_W-1:0]   glyph_width,
  input  logic [gbc_pkg::GDIM_W-1:0]   glyph_height,
  input  logic                         pen_color,
  input  logic [gbc_pkg::BYTE_W-1:0]   bitmap_byte,
  input  logic [gbc_pkg::RADDR_W-1:0]  read_address,
  output logic                         uop_valid,
  input  logic                         uop_ready,
  output gbc_pkg::uop_t                uop,
  output logic [AW-1:0]                uop_addr
);
  import gbc_pkg::*;

  logic [POS_W-1:0]  glyph_left, glyph_top;
  logic [GDIM_W-1:0] glyph_cols, glyph_rows, current_row;
  logic [3:0]        byte_in_row;
  logic              pen_bit;

  logic              accept, active, byte_last, load1;
  logic [4:0]        per_row;
  logic [GDIM_W-1:0] col_base;
  logic [7:0]        cmask;
  logic signed [CRD_W-1:0] y_next, x_next;

  logic              s1_v, s1_read, s1_pen, s1_move;
  logic signed [CRD_W-1:0] s1_y, s1_x;
  logic [7:0]        s1_cmask, s1_bits;
  logic [RADDR_W-1:0] s1_raddr;
  logic [17:0]       prod;

  logic              s2_v, s2_read, s2_pen, s2_oob, s2_row_ok, s2_phase, s2_done;
  logic [AW-1:0]     s2_row_base;
  logic signed [8:0] s2_q;
  logic [15:0]       s2_wmask, s2_wbits;

  logic signed [8:0] c;
  logic              c_ok, at_edge, need_b;
  logic [7:0]        emask, bmask, bbits;

  assign per_row   = 5'((8'(glyph_cols) + 8'd7) >> 3);
  assign active    = (per_row != 5'd0) && (current_row < glyph_rows);
  assign byte_last = (5'(byte_in_row) + 5'd1) >= per_row;
  assign accept    = in_valid && in_ready;
  assign load1     = accept && ((op == OP_READ) || ((op == OP_BYTE) && active));

  assign col_base = {byte_in_row, 3'b000};
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      cmask[7-i] = (col_base + GDIM_W'(i)) < glyph_cols;
    end
  end
  assign y_next = $signed({glyph_top[POS_W-1], glyph_top}) + $signed({5'b0, current_row});
  assign x_next = $signed({glyph_left[POS_W-1], glyph_left}) + $signed({5'b0, col_base});

  assign s1_move  = s1_v && (!s2_v || s2_done);
  assign in_ready = !clr_busy && (!s1_v || s1_move);

  // glyph state
  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_left  <= '0;
      glyph_top   <= '0;
      glyph_cols  <= '0;
      glyph_rows  <= '0;
      pen_bit     <= 1'b0;
      current_row <= '0;
      byte_in_row <= '0;
    end else if (accept) begin
      case (op)
        OP_START: begin
          glyph_left  <= origin_x;
          glyph_top   <= origin_y;
          glyph_cols  <= (8'(glyph_width) > 8'(MAX_GLYPH_SIZE)) ?
                         GDIM_W'(MAX_GLYPH_SIZE) : glyph_width;
          glyph_rows  <= (8'(glyph_height) > 8'(MAX_GLYPH_SIZE)) ?
                         GDIM_W'(MAX_GLYPH_SIZE) : glyph_height;
          pen_bit     <= pen_color;
          current_row <= '0;
          byte_in_row <= '0;
        end
        OP_BYTE: begin
          if (active) begin
            if (byte_last) begin
              byte_in_row <= '0;
              current_row <= current_row + GDIM_W'(1);
            end else begin
              byte_in_row <= byte_in_row + 4'd1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // stage 1: pixel coordinates and column mask
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (!s1_v || s1_move) begin
      s1_v <= load1;
    end
  end

  always_ff @(posedge clk) begin
    if ((!s1_v || s1_move) && load1) begin
      s1_read  <= (op == OP_READ);
      s1_y     <= y_next;
      s1_x     <= x_next;
      s1_cmask <= cmask;
      s1_bits  <= bitmap_byte;
      s1_pen   <= pen_bit;
      s1_raddr <= read_address;
    end
  end

  // stage 2: row address and bit window, then one or two micro-ops
  assign prod = 18'(s1_y[9:0]) * 18'(stride);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v     <= 1'b0;
      s2_phase <= 1'b0;
    end else if (s1_move) begin
      s2_v     <= 1'b1;
      s2_phase <= 1'b0;
    end else if (s2_done) begin
      s2_v     <= 1'b0;
      s2_phase <= 1'b0;
    end else if (s2_v && uop_ready) begin
      s2_phase <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_read     <= s1_read;
      s2_pen      <= s1_pen;
      s2_oob      <= 32'(s1_raddr) >= 32'(MEM_DEPTH);
      s2_row_ok   <= !s1_y[CRD_W-1] && (s1_y[10:0] < {1'b0, scr_h});
      s2_row_base <= s1_read ? AW'(s1_raddr) : AW'(prod);
      s2_q        <= s1_x[CRD_W-1:3];
      s2_wmask    <= {s1_cmask, 8'h00} >> s1_x[2:0];
      s2_wbits    <= {s1_bits, 8'h00} >> s1_x[2:0];
    end
  end

  assign c       = s2_phase ? (s2_q + 9'sd1) : s2_q;
  assign c_ok    = !c[8] && (c[7:0] < stride);
  assign at_edge = (c[7:0] == (stride - 8'd1)) && (scr_w[2:0] != 3'd0);
  assign emask   = at_edge ? ~(8'hff >> scr_w[2:0]) : 8'hff;
  assign bmask   = s2_phase ? s2_wmask[7:0] : s2_wmask[15:8];
  assign bbits   = s2_phase ? s2_wbits[7:0] : s2_wbits[15:8];
  assign need_b  = |s2_wmask[7:0];
  assign s2_done = s2_v && uop_ready && (s2_read || s2_phase || !need_b);

  always_comb begin
    uop.kind = s2_read ? UOP_READ : UOP_RMW;
    uop.oob  = s2_oob;
    uop.pen  = s2_pen;
    uop.mask = (!s2_read && s2_row_ok && c_ok) ? (bmask & emask) : 8'h00;
    uop.bits = bbits;
  end

  assign uop_addr  = s2_read ? s2_row_base : (s2_row_base + AW'(c[7:0]));
  assign uop_valid = s2_v;

endmodule

/* hw/rtl/glyph_blit_1bpp_clipped_top.sv */
// glyph_blit_1bpp_clipped_top: 1bpp glyph blitter into an internal framebuffer
// path: a read word passes stage 1, stage 2, the read-modify-write stage and the output buffer
// throughput: one word per cycle while reads find room in the output buffer; a bitmap byte
//   that straddles two framebuffer bytes holds the issue stage for two read-modify-writes
// reset: a clearing pass writes zero to every framebuffer byte, one per cycle, covering
//   all MEM_DEPTH bytes (32768 by default) with in_ready low; config writes still taken
module glyph_blit_1bpp_clipped_top #(
  parameter int MAX_SCREEN_WIDTH  = 512,
  parameter int MAX_SCREEN_HEIGHT = 512,
  parameter int MAX_GLYPH_SIZE    = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [gbc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gbc_pkg::DIM_W-1:0]      cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [gbc_pkg::OP_W-1:0]       op,
  input  logic [gbc_pkg::POS_W-1:0]      origin_x,
  input  logic [gbc_pkg::POS_W-1:0]      origin_y,
  input  logic [gbc_pkg::GDIM_W-1:0]     glyph_width,
  input  logic [gbc_pkg::GDIM_W-1:0]     glyph_height,
  input  logic                           pen_color,
  input  logic [gbc_pkg::BYTE_W-1:0]     bitmap_byte,
  input  logic [gbc_pkg::RADDR_W-1:0]    read_address,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [gbc_pkg::BYTE_W-1:0]     read_data
);
  import gbc_pkg::*;

  localparam int MAX_STRIDE = (MAX_SCREEN_WIDTH + 7) / 8;
  localparam int MEM_DEPTH  = MAX_STRIDE * MAX_SCREEN_HEIGHT;
  localparam int AW         = $clog2(MEM_DEPTH);

  logic [DIM_W-1:0] screen_width, screen_height;
  logic [DIM_W-1:0] scr_w, scr_h;
  logic [7:0]       stride;

  logic             clr_busy;
  logic [AW-1:0]    clr_addr;

  logic             uop_valid, uop_ready, uop_fire;
  uop_t             uop;
  logic [AW-1:0]    uop_addr;

  logic             s4_v, s4_we, s4_read;
  uop_t             s4_uop;
  logic [AW-1:0]    s4_addr;
  logic             fwd_hit;
  logic [7:0]       fwd_data, old_data, new_data, rdata;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [7:0]       ram_wdata;

  logic [7:0]       ff_data [2];
  logic             wr_ptr, rd_ptr, push, pop;
  logic [1:0]       count;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= 10'd512;
      screen_height <= 10'd512;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign scr_w  = (12'(screen_width) > 12'(MAX_SCREEN_WIDTH)) ?
                  DIM_W'(MAX_SCREEN_WIDTH) : screen_width;
  assign scr_h  = (12'(screen_height) > 12'(MAX_SCREEN_HEIGHT)) ?
                  DIM_W'(MAX_SCREEN_HEIGHT) : screen_height;
  assign stride = 8'((11'(scr_w) + 11'd7) >> 3);

  // clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(MEM_DEPTH - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  gbc_issue #(
    .MAX_GLYPH_SIZE (MAX_GLYPH_SIZE),
    .MEM_DEPTH      (MEM_DEPTH),
    .AW             (AW)
  ) u_issue (
    .clk          (clk),
    .rst          (rst),
    .clr_busy     (clr_busy),
    .scr_w        (scr_w),
    .scr_h        (scr_h),
    .stride       (stride),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .origin_x     (origin_x),
    .origin_y     (origin_y),
    .glyph_width  (glyph_width),
    .glyph_height (glyph_height),
    .pen_color    (pen_color),
    .bitmap_byte  (bitmap_byte),
    .read_address (read_address),
    .uop_valid    (uop_valid),
    .uop_ready    (uop_ready),
    .uop          (uop),
    .uop_addr     (uop_addr)
  );

  // reads need a free output slot counting the one in flight
  assign pop       = out_valid && out_ready;
  assign uop_ready = (uop.kind != UOP_READ) ||
                     ((3'(count) + 3'(s4_read)) < (3'd2 + 3'(pop)));
  assign uop_fire  = uop_valid && uop_ready;

  gbc_ram #(
    .WIDTH (8),
    .DEPTH (MEM_DEPTH)
  ) u_fb (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (uop_addr),
    .rdata (rdata)
  );

  // read-modify-write stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v    <= 1'b0;
      fwd_hit <= 1'b0;
    end else begin
      s4_v    <= uop_fire;
      fwd_hit <= uop_fire && s4_we && (uop_addr == s4_addr);
    end
  end

  always_ff @(posedge clk) begin
    s4_uop   <= uop;
    s4_addr  <= uop_addr;
    fwd_data <= new_data;
  end

  assign s4_read  = s4_v && (s4_uop.kind == UOP_READ);
  assign s4_we    = s4_v && (s4_uop.kind == UOP_RMW) && (|s4_uop.mask);
  assign old_data = fwd_hit ? fwd_data : rdata;
  // clear pixels go to zero, set pixels or in the pen
  assign new_data = (old_data & ~(s4_uop.mask & ~s4_uop.bits)) |
                    (s4_uop.mask & s4_uop.bits & {8{s4_uop.pen}});

  assign ram_we    = clr_busy || s4_we;
  assign ram_waddr = clr_busy ? clr_addr : s4_addr;
  assign ram_wdata = clr_busy ? 8'h00 : new_data;

  // two-word output buffer
  assign push = s4_read;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ff_data[wr_ptr] <= s4_uop.oob ? 8'h00 : old_data;
    end
  end

  assign out_valid = (count != 2'd0);
  assign read_data = ff_data[rd_ptr];

endmodule

/* tb/sv/tb_glyph_blit_1bpp_clipped_top.sv */
// tb_glyph_blit_1bpp_clipped_top: self-checking testbench for the 1bpp clipped glyph blitter
// keeps its own framebuffer image, predicts every read word and checks it in order
// depends on gbc_pkg and glyph_blit_1bpp_clipped_top
module tb_glyph_blit_1bpp_clipped_top;
  import gbc_pkg::*;

  localparam int MAX_W = 512;
  localparam int MAX_H = 512;
  localparam int MAX_G = 64;
  localparam int FB_BYTES = ((MAX_W + 7) / 8) * MAX_H;
  localparam int DRAIN_CYCLES = 12;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [OP_W-1:0]    opc;
    logic [POS_W-1:0]   ox;
    logic [POS_W-1:0]   oy;
    logic [GDIM_W-1:0]  gw;
    logic [GDIM_W-1:0]  gh;
    logic               pen;
    logic [BYTE_W-1:0]  bits;
    logic [RADDR_W-1:0] addr;
  } blit_word_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [OP_W-1:0]      op = '0;
  logic [POS_W-1:0]     origin_x = '0;
  logic [POS_W-1:0]     origin_y = '0;
  logic [GDIM_W-1:0]    glyph_width = '0;
  logic [GDIM_W-1:0]    glyph_height = '0;
  logic                 pen_color = 1'b0;
  logic [BYTE_W-1:0]    bitmap_byte = '0;
  logic [RADDR_W-1:0]   read_address = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [BYTE_W-1:0]    read_data;

  glyph_blit_1bpp_clipped_top DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .op(op), .origin_x(origin_x),
    .origin_y(origin_y), .glyph_width(glyph_width), .glyph_height(glyph_height),
    .pen_color(pen_color), .bitmap_byte(bitmap_byte), .read_address(read_address),
    .out_valid(out_valid), .out_ready(out_ready), .read_data(read_data)
  );

  // framebuffer image and glyph cursor of the predictor
  logic [BYTE_W-1:0] frame_bytes [FB_BYTES];
  logic [DIM_W-1:0]  scr_w_reg = 10'd512;
  logic [DIM_W-1:0]  scr_h_reg = 10'd512;
  int                gl_left, gl_top, gl_cols, gl_rows, gl_row, gl_byte;
  logic              gl_pen;

  blit_word_t        word_queue[$];
  logic [BYTE_W-1:0] read_data_due[$];
  blit_word_t        nxt, taken;
  logic              in_fire = 1'b0;
  int                send_idle_pct = 0;
  int                recv_stall_pct = 0;
  int                hold_request = 0;
  int                hold_left = 0;
  int                fail_count = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic void paint_bitmap_byte(logic [BYTE_W-1:0] b);
    int per_row, ew, eh, stride, col, px, py, idx, bitpos, i;
    per_row = (gl_cols + 7) / 8;
    if (per_row == 0 || gl_row >= gl_rows) return;
    ew = (scr_w_reg > MAX_W) ? MAX_W : int'(scr_w_reg);
    eh = (scr_h_reg > MAX_H) ? MAX_H : int'(scr_h_reg);
    stride = (ew + 7) / 8;
    for (i = 0; i < 8; i++) begin
      col = gl_byte * 8 + i;
      px = gl_left + col;
      py = gl_top + gl_row;
      if (col < gl_cols && px >= 0 && py >= 0 && px < ew && py < eh) begin
        idx = py * stride + px / 8;
        bitpos = 7 - (px % 8);
        if (idx < FB_BYTES) begin
          if (b[7-i]) frame_bytes[idx][bitpos] = frame_bytes[idx][bitpos] | gl_pen;
          else frame_bytes[idx][bitpos] = 1'b0;
        end
      end
    end
    gl_byte++;
    if (gl_byte >= per_row) begin
      gl_byte = 0;
      gl_row++;
    end
  endfunction

  function automatic void apply_blit_word(blit_word_t w);
    case (w.opc)
      OP_START: begin
        gl_left = int'($signed(w.ox));
        gl_top = int'($signed(w.oy));
        gl_cols = (w.gw > MAX_G) ? MAX_G : int'(w.gw);
        gl_rows = (w.gh > MAX_G) ? MAX_G : int'(w.gh);
        gl_pen = w.pen;
        gl_row = 0;
        gl_byte = 0;
      end
      OP_BYTE: paint_bitmap_byte(w.bits);
      OP_READ: read_data_due.push_back((w.addr < FB_BYTES) ? frame_bytes[w.addr] : '0);
      default: ;
    endcase
  endfunction

  function automatic blit_word_t noise_word();
    blit_word_t w;
    w.opc = OP_W'($urandom_range(0, 3));
    w.ox = POS_W'($urandom_range(0, 2047));
    w.oy = POS_W'($urandom_range(0, 2047));
    w.gw = GDIM_W'($urandom_range(0, 127));
    w.gh = GDIM_W'($urandom_range(0, 127));
    w.pen = 1'($urandom_range(0, 1));
    w.bits = BYTE_W'($urandom_range(0, 255));
    w.addr = RADDR_W'($urandom_range(0, 32767));
    return w;
  endfunction

  function automatic void push_start(int x, int y, int gw, int gh, logic pen);
    blit_word_t w;
    w = noise_word();
    w.opc = OP_START;
    w.ox = x[POS_W-1:0];
    w.oy = y[POS_W-1:0];
    w.gw = gw[GDIM_W-1:0];
    w.gh = gh[GDIM_W-1:0];
    w.pen = pen;
    word_queue.push_back(w);
  endfunction

  function automatic void push_bitmap(int b);
    blit_word_t w;
    w = noise_word();
    w.opc = OP_BYTE;
    w.bits = b[BYTE_W-1:0];
    word_queue.push_back(w);
  endfunction

  function automatic void push_read(int a);
    blit_word_t w;
    w = noise_word();
    w.opc = OP_READ;
    w.addr = a[RADDR_W-1:0];
    word_queue.push_back(w);
  endfunction

  function automatic void push_unused();
    blit_word_t w;
    w = noise_word();
    w.opc = OP_UNUSED;
    word_queue.push_back(w);
  endfunction

  function automatic int probe_addr(int x, int y, int ew, int eh);
    if (x >= 0 && y >= 0 && x < ew && y < eh) return y * ((ew + 7) / 8) + x / 8;
    return $urandom_range(0, 32767);
  endfunction

  function automatic int random_bitmap();
    case ($urandom_range(0, 3))
      0: return 255;
      1: return 0;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  // mostly complete glyphs with random content, some truncated or with surplus bytes
  function automatic void queue_random_glyphs(int n_words, int ew, int eh);
    int done, r, gw, gh, ox, oy, n_bytes, k, j;
    done = 0;
    // leftover bytes land on whatever glyph the last phase left open
    for (j = $urandom_range(0, 3); j > 0; j--) begin
      push_bitmap(random_bitmap());
      done++;
    end
    while (done < n_words) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        gw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 20);
        gh = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 8);
        if ($urandom_range(0, 6) == 0) begin
          ox = $urandom_range(0, 2047) - 1024;
          oy = $urandom_range(0, 2047) - 1024;
        end else begin
          ox = $urandom_range(0, ew + 16) - 12;
          oy = $urandom_range(0, eh + 8) - 6;
        end
        push_start(ox, oy, gw, gh, $urandom_range(0, 4) != 0);
        done++;
        n_bytes = (((gw > MAX_G ? MAX_G : gw) + 7) / 8) * (gh > MAX_G ? MAX_G : gh);
        k = $urandom_range(0, 9);
        if (k == 0) n_bytes = $urandom_range(0, n_bytes);
        else if (k == 1) n_bytes += $urandom_range(1, 3);
        if (n_bytes > 40) n_bytes = 40;
        for (j = 0; j < n_bytes; j++) begin
          push_bitmap(random_bitmap());
          done++;
          if ($urandom_range(0, 7) == 0) begin
            push_read(probe_addr(ox + $urandom_range(0, gw), oy + $urandom_range(0, gh), ew, eh));
            done++;
          end
        end
        for (j = $urandom_range(1, 3); j > 0; j--) begin
          push_read(probe_addr(ox + $urandom_range(0, gw), oy + $urandom_range(0, gh), ew, eh));
          done++;
        end
      end else if (r < 92) begin
        push_read($urandom_range(0, 32767));
        done++;
      end else if (r < 96) begin
        push_bitmap($urandom_range(0, 255));
        done++;
      end else begin
        push_unused();
      end
    end
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[DIM_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (word_queue.size() != 0 || in_valid || read_data_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // word driver
  always @(posedge clk) in_fire <= in_valid && in_ready;

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (word_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = word_queue.pop_front();
        op <= nxt.opc;
        origin_x <= nxt.ox;
        origin_y <= nxt.oy;
        glyph_width <= nxt.gw;
        glyph_height <= nxt.gh;
        pen_color <= nxt.pen;
        bitmap_byte <= nxt.bits;
        read_address <= nxt.addr;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver, with an optional long hold-off
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // monitor: track config, predict accepted words, check read words
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_SCREEN_WIDTH) scr_w_reg = cfg_data;
        else scr_h_reg = cfg_data;
      end
      if (in_valid && in_ready) begin
        taken.opc = op;
        taken.ox = origin_x;
        taken.oy = origin_y;
        taken.gw = glyph_width;
        taken.gh = glyph_height;
        taken.pen = pen_color;
        taken.bits = bitmap_byte;
        taken.addr = read_address;
        apply_blit_word(taken);
      end
      if (out_valid && out_ready) begin
        if (read_data_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected read word at %0t: read_data %02h", $time, read_data);
        end else if (read_data !== read_data_due[0]) begin
          fail_count++;
          if (fail_count <= 10)
            $display("read_data mismatch at %0t: expected %02h got %02h",
                     $time, read_data_due[0], read_data);
          void'(read_data_due.pop_front());
        end else begin
          void'(read_data_due.pop_front());
        end
      end
    end
  end

  initial begin
    int p, sw, sh, ew, eh;
    int idle_send [6];
    int idle_recv [6];
    idle_send = '{0, 85, 0, 27, 0, 27};
    idle_recv = '{0, 0, 85, 27, 0, 27};
    for (int i = 0; i < FB_BYTES; i++) frame_bytes[i] = '0;
    gl_left = 0; gl_top = 0; gl_cols = 0; gl_rows = 0; gl_row = 0; gl_byte = 0; gl_pen = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_reg(REG_SCREEN_WIDTH, 512);
    write_reg(REG_SCREEN_HEIGHT, 512);

    // directed words
    push_start(0, 0, 8, 2, 1'b1);
    push_bitmap(8'hFF);
    push_bitmap(8'h81);
    push_read(0);
    push_read(64);
    // straddles two framebuffer bytes, padding bits set
    push_start(5, 2, 12, 1, 1'b1);
    push_bitmap(8'hAB);
    push_bitmap(8'hCF);
    push_read(128);
    push_read(129);
    // clear pen leaves set pixels alone
    push_start(3, 0, 8, 1, 1'b0);
    push_bitmap(8'hF0);
    push_read(0);
    push_start(-1024, -1024, 127, 127, 1'b1);
    push_bitmap(8'hFF);
    push_start(1023, 1023, 64, 64, 1'b1);
    push_bitmap(8'hFF);
    push_start(0, 4, 0, 5, 1'b1);
    push_bitmap(8'hFF);
    push_unused();
    push_start(-1, -1, 8, 2, 1'b1);
    push_bitmap(8'h55);
    push_bitmap(8'h55);
    push_bitmap(8'h77);
    push_read(0);
    push_read(32767);
    wait_idle();

    for (p = 0; p < 6; p++) begin
      case (p)
        0: begin sw = 512; sh = 512; end
        1: begin sw = 1023; sh = 1023; end
        2: begin sw = $urandom_range(1, 512); sh = $urandom_range(1, 512); end
        3: begin sw = 0; sh = 0; end
        4: begin sw = 1; sh = 1; end
        default: begin sw = $urandom_range(8, 64); sh = $urandom_range(8, 64); end
      endcase
      write_reg(REG_SCREEN_WIDTH, sw);
      write_reg(REG_SCREEN_HEIGHT, sh);
      ew = (sw > MAX_W) ? MAX_W : sw;
      eh = (sh > MAX_H) ? MAX_H : sh;
      send_idle_pct = idle_send[p];
      recv_stall_pct = idle_recv[p];
      @(posedge clk);
      // receiver holds off while words keep coming, filling the pipeline
      if (p == 0) hold_request = 400;
      queue_random_glyphs(70, ew, eh);
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("** glyph_blit_1bpp_clipped_top: PASSED **");
    end else begin
      $display("** glyph_blit_1bpp_clipped_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("** glyph_blit_1bpp_clipped_top: FAILED **");
    $finish;
  end

endmodule
